>>> design/pdp8_instruction_step_unit_defines.svh
// Assertion macros for the PDP-8 instruction step unit.
// No dependencies; included by the files that carry assertions.
`ifndef PDP8_INSTRUCTION_STEP_UNIT_DEFINES_SVH
`define PDP8_INSTRUCTION_STEP_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define PDP8S_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PDP8S_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pdp8s_pkg.sv
// Shared types and constants for the PDP-8 instruction step unit.
// No dependencies; imported by every module of the block.
package pdp8s_pkg;

  localparam int MEM_WORDS_DEF = 4096;
  localparam int WORD_W        = 12;
  localparam int CYC_W         = 48;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CYC_W-1:0]  cyc_t;

  localparam cyc_t CYC_MAX = '1;

  // Item commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SETPC = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  // Major opcodes, instruction bits 11:9
  typedef enum logic [2:0] {
    OP_AND, OP_TAD, OP_ISZ, OP_DCA, OP_JMS, OP_JMP, OP_IOT, OP_OPR
  } opcode_t;

  // IOT device codes, instruction bits 8:3
  localparam logic [5:0] DEV_KBD = 6'd3;
  localparam logic [5:0] DEV_TTY = 6'd4;

  // Memory reference bit positions
  localparam int IR_IND  = 8;
  localparam int IR_PAGE = 7;

  // Operate bit positions (group select, group 1, group 2)
  localparam int IR_GRP2 = 8;
  localparam int IR_CLA  = 7;
  localparam int IR_CLL  = 6;
  localparam int IR_CMA  = 5;
  localparam int IR_CML  = 4;
  localparam int IR_RAR  = 3;
  localparam int IR_RAL  = 2;
  localparam int IR_TWO  = 1;
  localparam int IR_IAC  = 0;
  localparam int IR_SMA  = 6;
  localparam int IR_SZA  = 5;
  localparam int IR_SNL  = 4;
  localparam int IR_RSS  = 3;
  localparam int IR_HLT  = 1;
  localparam int IR_HLT0 = 0;

  // Result of an operate instruction
  typedef struct packed {
    word_t      acc;
    logic       lnk;
    logic       halt;
    logic [1:0] pc_step;
  } opr_res_t;

endpackage

>>> design/pdp8s_mem.sv
// Main memory: single-port synchronous RAM, registered read.
// Depends on pdp8s_pkg for the word type.
module pdp8s_mem #(
  parameter int MEM_WORDS = pdp8s_pkg::MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MEM_WORDS)-1:0] addr,
  input  pdp8s_pkg::word_t             wdata,
  output pdp8s_pkg::word_t             rdata
);
  import pdp8s_pkg::*;

  word_t mem [MEM_WORDS];

  // Write or read the addressed word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/pdp8s_opr.sv
// Operate instruction unit: group 1 and group 2 microcoded operations.
// Depends on pdp8s_pkg for bit positions and the result struct.
module pdp8s_opr (
  input  pdp8s_pkg::word_t    ir,
  input  pdp8s_pkg::word_t    acc,
  input  logic                lnk,
  output pdp8s_pkg::opr_res_t res
);
  import pdp8s_pkg::*;

  always_comb begin
    logic [WORD_W:0] v;
    logic [WORD_W:0] s;
    word_t           a;
    logic            l;
    logic            skip;
    logic            hlt;

    a    = acc;
    l    = lnk;
    v    = '0;
    s    = '0;
    skip = 1'b0;
    hlt  = 1'b0;
    if (!ir[IR_GRP2]) begin
      // Group 1: clear, complement, increment in sequence
      if (ir[IR_CLA]) a = '0;
      if (ir[IR_CLL]) l = 1'b0;
      if (ir[IR_CMA]) a = ~a;
      if (ir[IR_CML]) l = ~l;
      if (ir[IR_IAC]) begin
        s = {1'b0, a} + 13'd1;
        l = l ^ s[WORD_W];
        a = s[WORD_W-1:0];
      end
      hlt = ir[IR_RAR] & ir[IR_RAL];
      // Rotate link and accumulator as one 13-bit ring
      v = {l, a};
      if (!hlt) begin
        if (ir[IR_RAR]) begin
          v = {v[0], v[WORD_W:1]};
          if (ir[IR_TWO]) v = {v[0], v[WORD_W:1]};
        end else if (ir[IR_RAL]) begin
          v = {v[WORD_W-1:0], v[WORD_W]};
          if (ir[IR_TWO]) v = {v[WORD_W-1:0], v[WORD_W]};
        end
      end
      res.acc     = v[WORD_W-1:0];
      res.lnk     = v[WORD_W];
      res.halt    = hlt;
      res.pc_step = hlt ? 2'd0 : 2'd1;
    end else begin
      // Group 2: skip tests on the old accumulator, then clear
      skip = (ir[IR_SMA] & acc[WORD_W-1]) | (ir[IR_SZA] & (acc == '0)) |
             (ir[IR_SNL] & lnk);
      skip = skip ^ ir[IR_RSS];
      if (ir[IR_CLA]) a = '0;
      hlt = ir[IR_HLT] | ir[IR_HLT0];
      res.acc     = a;
      res.lnk     = l;
      res.halt    = hlt;
      res.pc_step = hlt ? 2'd0 : (skip ? 2'd2 : 2'd1);
    end
  end

endmodule

>>> design/pdp8_instruction_step_unit.sv
// PDP-8 style instruction step unit: sequencer around one shared memory port.
// Depends on pdp8s_pkg, pdp8s_mem, pdp8s_opr and the assertion macro header.
//
// Usage: the input channel (in_valid/in_stall) carries one item: load a
// memory word, set the program counter (clears halt), or execute one
// instruction. Every item yields exactly one result on the output channel
// (out_valid/out_stall), held in an output register until it transfers.
// Steps per item, each memory step using the single memory port: load,
// set PC and a halted execute go straight to the result; an operate
// instruction takes only the fetch; AND, TAD, ISZ, DCA, JMS, JMP and IOT
// take the fetch, an indirect read when indirect, then an operand or
// execute step. The next item is accepted in the cycle the result is
// registered into the output register. After the last memory step a
// result waits in the sequencer's done state until that register frees.
// Reset: a clearing pass writes zero to all 4096 words, one per cycle;
// in_stall stays high until the pass ends. If the receiver stalls, the
// next item still runs; its result waits in the sequencer and in_stall
// stays high until the output register frees.
`include "pdp8_instruction_step_unit_defines.svh"

module pdp8_instruction_step_unit #(
  parameter int MEM_WORDS = pdp8s_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [11:0] address,
  input  logic [11:0] word,
  input  logic [11:0] input_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] instr_addr,
  output logic [11:0] instr_word,
  output logic [11:0] acc_value,
  output logic        link_value,
  output logic        halted,
  output logic        char_valid,
  output logic [7:0]  char_out,
  output logic        input_used,
  output logic [47:0] cycles
);
  import pdp8s_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_INDIR, ST_OPER, ST_EXEC, ST_DONE
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  word_t           pc;
  word_t           acc;
  logic            lnk;
  logic            halt;
  cyc_t            cyc;
  word_t           ir;
  word_t           ea;
  word_t           inch;
  word_t           pc_before;
  word_t           iword;
  logic            chv;
  logic [7:0]      cho;
  logic            used;

  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  word_t           mem_wdata;
  word_t           mem_rdata;

  opr_res_t        opr_res;
  opcode_t         op;
  opcode_t         f_op;
  word_t           ea0;
  word_t           isz_val;
  logic [WORD_W:0] tad_sum;
  cyc_t            cyc_inc;
  logic            out_free;
  logic            out_load;
  logic            take;
  logic            accept;

  function automatic logic reads_operand(opcode_t o);
    return (o == OP_AND) || (o == OP_TAD) || (o == OP_ISZ);
  endfunction

  pdp8s_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  pdp8s_opr u_opr (
    .ir  (mem_rdata),
    .acc (acc),
    .lnk (lnk),
    .res (opr_res)
  );

  // Decode the fetched word and the held instruction
  assign op      = opcode_t'(ir[11:9]);
  assign f_op    = opcode_t'(mem_rdata[11:9]);
  assign ea0     = {(mem_rdata[IR_PAGE] ? pc[11:7] : 5'd0), mem_rdata[6:0]};
  assign isz_val = mem_rdata + 12'd1;
  assign tad_sum = {1'b0, acc} + {1'b0, mem_rdata};
  assign cyc_inc = (cyc == CYC_MAX) ? cyc : cyc + 48'd1;

  // Handshake: take a new item when idle or while handing off a result
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == ST_DONE) && out_free;
  assign take     = (state == ST_IDLE) || out_load;
  assign in_stall = !take;
  assign accept   = in_valid && take;

  // Memory port arbitration by sequencer step
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = AW'(pc);
    mem_wdata = acc;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE, ST_DONE: begin
        if (accept && (cmd == CMD_LOAD)) begin
          mem_we    = 1'b1;
          mem_addr  = AW'(address);
          mem_wdata = word;
        end
      end
      ST_FETCH: mem_addr = AW'(ea0);
      ST_INDIR: mem_addr = AW'(mem_rdata);
      ST_OPER: begin
        if (op == OP_ISZ) begin
          mem_we    = 1'b1;
          mem_addr  = AW'(ea);
          mem_wdata = isz_val;
        end
      end
      ST_EXEC: begin
        if (op == OP_DCA) begin
          mem_we    = 1'b1;
          mem_addr  = AW'(ea);
          mem_wdata = acc;
        end else if (op == OP_JMS) begin
          mem_we    = 1'b1;
          mem_addr  = AW'(ea);
          mem_wdata = pc;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, machine registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pc        <= '0;
      acc       <= '0;
      lnk       <= 1'b0;
      halt      <= 1'b0;
      cyc       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load or drop the output register
      if (out_load) begin
        out_valid  <= 1'b1;
        instr_addr <= pc_before;
        instr_word <= iword;
        acc_value  <= acc;
        link_value <= lnk;
        halted     <= halt;
        char_valid <= chv;
        char_out   <= cho;
        input_used <= used;
        cycles     <= cyc;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MEM_WORDS - 1)) state <= ST_IDLE;
        end
        ST_IDLE, ST_DONE: begin
          if (accept) begin
            pc_before <= pc;
            iword     <= '0;
            chv       <= 1'b0;
            cho       <= '0;
            used      <= 1'b0;
            inch      <= input_char;
            unique case (cmd)
              CMD_LOAD: state <= ST_DONE;
              CMD_SETPC: begin
                pc    <= address;
                halt  <= 1'b0;
                state <= ST_DONE;
              end
              CMD_EXEC: state <= halt ? ST_DONE : ST_FETCH;
              default:  state <= ST_DONE;
            endcase
          end else if (out_load) begin
            state <= ST_IDLE;
          end
        end
        ST_FETCH: begin
          ir    <= mem_rdata;
          iword <= mem_rdata;
          cyc   <= cyc_inc;
          if (f_op == OP_OPR) begin
            acc   <= opr_res.acc;
            lnk   <= opr_res.lnk;
            halt  <= opr_res.halt;
            pc    <= pc + word_t'(opr_res.pc_step);
            state <= ST_DONE;
          end else begin
            pc <= pc + 12'd1;
            ea <= ea0;
            if (mem_rdata[IR_IND]) state <= ST_INDIR;
            else if (reads_operand(f_op)) state <= ST_OPER;
            else state <= ST_EXEC;
          end
        end
        ST_INDIR: begin
          ea    <= mem_rdata;
          cyc   <= cyc_inc;
          state <= reads_operand(op) ? ST_OPER : ST_EXEC;
        end
        ST_OPER: begin
          cyc   <= cyc_inc;
          state <= ST_DONE;
          case (op)
            OP_AND: acc <= acc & mem_rdata;
            OP_TAD: begin
              acc <= tad_sum[WORD_W-1:0];
              lnk <= lnk ^ tad_sum[WORD_W];
            end
            OP_ISZ: if (isz_val == '0) pc <= pc + 12'd1;
            default: ;
          endcase
        end
        ST_EXEC: begin
          state <= ST_DONE;
          case (op)
            OP_DCA: begin
              acc <= '0;
              cyc <= cyc_inc;
            end
            OP_JMS: begin
              pc  <= ea + 12'd1;
              cyc <= cyc_inc;
            end
            OP_JMP: pc <= ea;
            OP_IOT: begin
              if (ir[8:3] == DEV_KBD) begin
                acc  <= inch;
                used <= 1'b1;
              end else if (ir[8:3] == DEV_TTY) begin
                chv <= 1'b1;
                cho <= acc[7:0];
              end else begin
                halt <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PDP8S_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && !in_stall,
    state != ST_IDLE, "accepted item left sequencer idle")
  `PDP8S_ASSERT_SAME(a_clear_quiet, clk, rst, state == ST_CLEAR,
    !out_valid && in_stall, "activity during memory clear")
  `PDP8S_ASSERT_SAME(a_read_steps, clk, rst, state == ST_FETCH || state == ST_INDIR,
    !mem_we, "memory written during a read step")
  `PDP8S_ASSERT_SAME(a_cycles_grow, clk, rst, !$past(rst),
    cyc >= $past(cyc), "cycle count went backward")
  `PDP8S_ASSERT_SAME(a_char_quiet, clk, rst, out_valid && !char_valid,
    char_out == 8'd0, "stray output byte")

endmodule

>>> sim/tb_top.sv
// Self-checking bench for the PDP-8 instruction step unit: loads, PC sets, executes.
// Depends on pdp8s_pkg and pdp8_instruction_step_unit; predicts each report internally.
`timescale 1ns / 1ps

module tb_top;
  import pdp8s_pkg::*;

  localparam logic [1:0] CMD_NONE    = 2'd3;   // unused command, block reports it without changing state
  localparam int         TOTAL_ITEMS  = 600;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         QUIET_LIMIT  = 16000; // covers the memory clear after reset
  localparam int         TAIL_CYCLES  = 16;
  localparam int         SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [1:0] cmd;
    word_t      address;
    word_t      word;
    word_t      input_char;
  } step_item_t;

  typedef struct packed {
    word_t      instr_addr;
    word_t      instr_word;
    word_t      acc_value;
    logic       link_value;
    logic       halted;
    logic       char_valid;
    logic [7:0] char_out;
    logic       input_used;
    cyc_t       cycles;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_LOAD;
  logic [11:0] address = '0;
  logic [11:0] word = '0;
  logic [11:0] input_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] instr_addr;
  logic [11:0] instr_word;
  logic [11:0] acc_value;
  logic        link_value;
  logic        halted;
  logic        char_valid;
  logic [7:0]  char_out;
  logic        input_used;
  logic [47:0] cycles;

  pdp8_instruction_step_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .address    (address),
    .word       (word),
    .input_char (input_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .instr_addr (instr_addr),
    .instr_word (instr_word),
    .acc_value  (acc_value),
    .link_value (link_value),
    .halted     (halted),
    .char_valid (char_valid),
    .char_out   (char_out),
    .input_used (input_used),
    .cycles     (cycles)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Machine image kept by the bench
  word_t core_mem [0:4095];
  word_t core_pc;
  word_t core_ac;
  logic  core_link;
  cyc_t  core_cycles;
  logic  core_halt;

  step_item_t cmd_items[$];
  report_t    step_reports[$];
  step_item_t on_bus;

  logic idle_on = 1'b0;
  logic hold_start = 1'b0;
  int   send_gap;
  int   rcv_gap;
  int   hold_count;
  int   quiet_cycles;
  int   queued_items = 0;
  int   live_items = 0;
  int   exec_count = 0;
  int   halt_count = 0;
  int   checked = 0;
  int   errors = 0;

  function automatic void count_cycle();
    if (core_cycles != CYC_MAX) core_cycles = core_cycles + 1'b1;
  endfunction

  // Add into the accumulator; carry out flips the link
  function automatic void add_to_ac(word_t n);
    logic [12:0] sum;
    sum = {1'b0, core_ac} + {1'b0, n};
    if (sum[12]) core_link = ~core_link;
    core_ac = sum[11:0];
  endfunction

  // Apply one item to the machine image and return the report it causes
  function automatic report_t pdp8_step(step_item_t it);
    report_t r;
    word_t   ir;
    word_t   ea;
    logic    skip;
    r = '0;
    r.instr_addr = core_pc;
    case (it.cmd)
      CMD_LOAD: core_mem[it.address] = it.word;
      CMD_SETPC: begin
        core_pc = it.address;
        core_halt = 1'b0;
      end
      CMD_EXEC: if (!core_halt) begin
        ir = core_mem[core_pc];
        r.instr_word = ir;
        count_cycle();
        if (ir[11:9] == OP_OPR && !ir[IR_GRP2]) begin
          // group 1: clear, complement, increment, then rotate
          if (ir[IR_CLA]) core_ac = '0;
          if (ir[IR_CLL]) core_link = 1'b0;
          if (ir[IR_CMA]) core_ac = ~core_ac;
          if (ir[IR_CML]) core_link = ~core_link;
          if (ir[IR_IAC]) add_to_ac(12'd1);
          if (ir[IR_RAR] && ir[IR_RAL]) begin
            core_halt = 1'b1;
          end else begin
            if (ir[IR_RAR]) begin
              {core_link, core_ac} = {core_ac[0], core_link, core_ac[11:1]};
              if (ir[IR_TWO]) {core_link, core_ac} = {core_ac[0], core_link, core_ac[11:1]};
            end else if (ir[IR_RAL]) begin
              {core_link, core_ac} = {core_ac, core_link};
              if (ir[IR_TWO]) {core_link, core_ac} = {core_ac, core_link};
            end
            core_pc = core_pc + 1'b1;
          end
        end else if (ir[11:9] == OP_OPR) begin
          // group 2: skip test, then clear, then halt or advance
          skip = (ir[IR_SMA] && core_ac[11]) || (ir[IR_SZA] && core_ac == '0) ||
                 (ir[IR_SNL] && core_link);
          if (ir[IR_RSS]) skip = !skip;
          if (ir[IR_CLA]) core_ac = '0;
          if (ir[IR_HLT] || ir[IR_HLT0]) begin
            core_halt = 1'b1;
          end else begin
            core_pc = core_pc + 1'b1;
            if (skip) core_pc = core_pc + 1'b1;
          end
        end else begin
          // memory reference and IOT share the address step
          ea = {5'd0, ir[6:0]};
          if (ir[IR_PAGE]) ea[11:7] = core_pc[11:7];
          if (ir[IR_IND]) begin
            ea = core_mem[ea];
            count_cycle();
          end
          core_pc = core_pc + 1'b1;
          case (opcode_t'(ir[11:9]))
            OP_AND: begin
              core_ac = core_ac & core_mem[ea];
              count_cycle();
            end
            OP_TAD: begin
              add_to_ac(core_mem[ea]);
              count_cycle();
            end
            OP_ISZ: begin
              core_mem[ea] = core_mem[ea] + 1'b1;
              count_cycle();
              if (core_mem[ea] == '0) core_pc = core_pc + 1'b1;
            end
            OP_DCA: begin
              core_mem[ea] = core_ac;
              count_cycle();
              core_ac = '0;
            end
            OP_JMS: begin
              core_mem[ea] = core_pc;
              count_cycle();
              core_pc = ea + 1'b1;
            end
            OP_JMP: core_pc = ea;
            default: begin
              if (ir[8:3] == DEV_KBD) begin
                core_ac = it.input_char;
                r.input_used = 1'b1;
              end else if (ir[8:3] == DEV_TTY) begin
                r.char_valid = 1'b1;
                r.char_out = core_ac[7:0];
              end else begin
                core_halt = 1'b1;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    r.acc_value = core_ac;
    r.link_value = core_link;
    r.halted = core_halt;
    r.cycles = core_cycles;
    return r;
  endfunction

  // Driver: offer queued items, hold each until it transfers
  always @(posedge clk) begin
    logic offering;
    logic was_halted;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        was_halted = core_halt;
        if (on_bus.cmd == CMD_LOAD || on_bus.cmd == CMD_SETPC ||
            (on_bus.cmd == CMD_EXEC && !core_halt)) live_items++;
        if (on_bus.cmd == CMD_EXEC && !core_halt) exec_count++;
        step_reports.push_back(pdp8_step(on_bus));
        if (core_halt && !was_halted) halt_count++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_items.size() > 0) begin
          on_bus = cmd_items.pop_front();
          cmd <= on_bus.cmd;
          address <= on_bus.address;
          word <= on_bus.word;
          input_char <= on_bus.input_char;
          offering = 1'b1;
          send_gap = idle_on ? $urandom_range(0, 12) : 0;
        end
      end
      in_valid <= offering;
    end
  end

  // Monitor: check each transfer against the oldest prediction, then pick stall
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rcv_gap = 0;
      hold_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {instr_addr, instr_word, acc_value, link_value, halted, char_valid,
               char_out, input_used, cycles};
        if (step_reports.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("unexpected report: pc=%o ir=%o ac=%o", got.instr_addr,
                     got.instr_word, got.acc_value);
        end else begin
          want = step_reports.pop_front();
          checked++;
          if (got !== want) begin
            errors++;
            if (errors <= SHOWN_ERRORS) begin
              $display("mismatch on report %0d: expected pc=%o ir=%o ac=%o l=%b hlt=%b",
                       checked, want.instr_addr, want.instr_word, want.acc_value,
                       want.link_value, want.halted);
              $display("  expected chv=%b ch=%h inu=%b cyc=%0d", want.char_valid,
                       want.char_out, want.input_used, want.cycles);
              $display("  got      pc=%o ir=%o ac=%o l=%b hlt=%b", got.instr_addr,
                       got.instr_word, got.acc_value, got.link_value, got.halted);
              $display("  got      chv=%b ch=%h inu=%b cyc=%0d", got.char_valid,
                       got.char_out, got.input_used, got.cycles);
            end
          end
        end
        rcv_gap = idle_on ? $urandom_range(0, 12) : 0;
      end
      if (hold_start && hold_count < HOLD_CYCLES) begin
        hold_count++;
        out_stall <= 1'b1;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic queue_item(logic [1:0] c, word_t a, word_t w, word_t ch);
    step_item_t it;
    it.cmd = c;
    it.address = a;
    it.word = w;
    it.input_char = ch;
    cmd_items.push_back(it);
    queued_items++;
  endtask

  function automatic word_t pick_data();
    case ($urandom_range(0, 5))
      0: return 12'o0000;
      1: return 12'o7777;
      2: return 12'o7776;
      default: return word_t'($urandom_range(0, 4095));
    endcase
  endfunction

  // Mostly instructions that keep running; a few halt or use raw encodings
  function automatic word_t pick_instr();
    word_t ir;
    int    k;
    ir = word_t'($urandom_range(0, 4095));
    k = $urandom_range(0, 99);
    if (k < 45) begin
      ir[11:9] = 3'($urandom_range(0, 5));
      if ($urandom_range(0, 3) != 0) ir[6:0] = 7'o170 + 7'($urandom_range(0, 7));
    end else if (k < 56) begin
      ir[11:9] = OP_IOT;
      ir[8:3] = $urandom_range(0, 1) ? DEV_KBD : DEV_TTY;
    end else if (k < 59) begin
      ir[11:9] = OP_IOT;
    end else if (k < 94) begin
      ir[11:9] = OP_OPR;
      if (ir[IR_GRP2]) ir[1:0] = 2'b00;
      else if (ir[IR_RAR] && ir[IR_RAL]) ir[$urandom_range(0, 1) ? IR_RAR : IR_RAL] = 1'b0;
    end else begin
      ir[11:9] = OP_OPR;
    end
    return ir;
  endfunction

  // Well-formed run: load code and data near a random origin, set PC, step it
  task automatic queue_program();
    word_t org;
    word_t a;
    int    n;
    org = ($urandom_range(0, 7) == 0) ? 12'o7770 + word_t'($urandom_range(0, 7))
                                      : word_t'($urandom_range(0, 4095));
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) queue_item(CMD_LOAD, org + word_t'(i), pick_instr(), '0);
    for (int i = 0; i < 4; i++) begin
      a = {5'd0, 7'o170 + 7'($urandom_range(0, 7))};
      if ($urandom_range(0, 1)) a[11:7] = org[11:7];
      queue_item(CMD_LOAD, a, pick_data(), '0);
    end
    queue_item(CMD_SETPC, org, word_t'($urandom_range(0, 4095)), '0);
    repeat (n + $urandom_range(0, 6))
      queue_item(CMD_EXEC, word_t'($urandom_range(0, 4095)), word_t'($urandom_range(0, 4095)),
                 $urandom_range(0, 7) == 0 ? 12'o7777 : word_t'($urandom_range(0, 4095)));
  endtask

  // Noise: any command, including the unused one, with random fields
  task automatic queue_noise();
    repeat ($urandom_range(1, 6))
      queue_item(2'($urandom_range(0, 3)), word_t'($urandom_range(0, 4095)),
                 word_t'($urandom_range(0, 4095)), word_t'($urandom_range(0, 4095)));
  endtask

  initial begin
    logic paused_once;
    paused_once = 1'b0;
    // Start the machine image from the reset state: memory and registers zero
    foreach (core_mem[i]) core_mem[i] = '0;
    core_pc = '0;
    core_ac = '0;
    core_link = 1'b0;
    core_cycles = '0;
    core_halt = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: PC wrap, TAD carry, input and output devices, JMS and ISZ wrap, halts
    queue_item(CMD_LOAD,  12'o7777, 12'o7001, 12'o0000);  // IAC
    queue_item(CMD_SETPC, 12'o7777, 12'o0000, 12'o0000);
    queue_item(CMD_EXEC,  12'o0000, 12'o0000, 12'o0000);  // PC wraps to zero
    queue_item(CMD_LOAD,  12'o0000, 12'o1377, 12'o0000);  // TAD current page 0177
    queue_item(CMD_LOAD,  12'o0177, 12'o7777, 12'o0000);
    queue_item(CMD_EXEC,  12'o0000, 12'o0000, 12'o0000);  // carry flips link
    queue_item(CMD_LOAD,  12'o0001, 12'o6031, 12'o0000);  // keyboard read
    queue_item(CMD_EXEC,  12'o0000, 12'o0000, 12'o7777);  // end-of-input value
    queue_item(CMD_LOAD,  12'o0002, 12'o6041, 12'o0000);  // teleprinter write
    queue_item(CMD_EXEC,  12'o7777, 12'o7777, 12'o0000);
    queue_item(CMD_LOAD,  12'o0003, 12'o4777, 12'o0000);  // JMS indirect to 7777
    queue_item(CMD_EXEC,  12'o0000, 12'o0000, 12'o0000);  // target wraps to zero
    queue_item(CMD_LOAD,  12'o7776, 12'o2377, 12'o0000);  // ISZ 7777
    queue_item(CMD_LOAD,  12'o7777, 12'o7777, 12'o0000);
    queue_item(CMD_SETPC, 12'o7776, 12'o0000, 12'o0000);
    queue_item(CMD_EXEC,  12'o0000, 12'o0000, 12'o0000);  // skip wraps past 7777
    queue_item(CMD_LOAD,  12'o0000, 12'o7402, 12'o0000);  // group 2 halt
    queue_item(CMD_EXEC,  12'o0000, 12'o0000, 12'o0000);
    queue_item(CMD_EXEC,  12'o0000, 12'o0000, 12'o0000);  // ignored while halted
    queue_item(CMD_NONE,  12'o7777, 12'o7777, 12'o7777);
    queue_item(CMD_LOAD,  12'o0005, 12'o6000, 12'o0000);  // IOT to unknown device
    queue_item(CMD_SETPC, 12'o0005, 12'o0000, 12'o0000);
    queue_item(CMD_EXEC,  12'o0000, 12'o0000, 12'o0000);
    queue_item(CMD_SETPC, 12'o0000, 12'o0000, 12'o0000);

    // Random: mostly short programs, some noise, with one long output hold
    // and one full drain before sending resumes
    while (queued_items < TOTAL_ITEMS) begin
      @(negedge clk);
      idle_on = ($urandom_range(0, 3) != 0);
      if (!hold_start && queued_items > 200) hold_start = 1'b1;
      if (!paused_once && queued_items > 400) begin
        while (cmd_items.size() > 0 || in_valid || step_reports.size() > 0) @(negedge clk);
        paused_once = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) queue_noise();
      else queue_program();
      while (cmd_items.size() > 32) @(negedge clk);
    end

    // Drain and let any stray report show up
    while (cmd_items.size() > 0 || in_valid) @(negedge clk);
    while (step_reports.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("summary: %0d live items, %0d instructions run, %0d halts reached",
             live_items, exec_count, halt_count);
    $display("summary: %0d reports checked, %0d errors", checked, errors);
    if (errors == 0 && step_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
